### sv/html_tag_stripper_unit_defines.svh
// assertion macros shared by the html tag stripper modules
`ifndef HTML_TAG_STRIPPER_UNIT_DEFINES_SVH
`define HTML_TAG_STRIPPER_UNIT_DEFINES_SVH

// condition holds at every edge out of reset
`define HTSU_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence holds in the same cycle
`define HTSU_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence holds in the next cycle
`define HTSU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/htsu_pkg.sv
// types, constants and byte decision function of the html tag stripper
package htsu_pkg;

	localparam int DEPTH_BITS   = 8;
	localparam int BRACKET_BITS = 8;
	localparam int QDEPTH       = 4;
	localparam int QPTR_BITS    = $clog2(QDEPTH);
	localparam int QCNT_BITS    = QPTR_BITS + 1;

	typedef enum logic [2:0] {
		MODE_TEXT    = 3'd0,
		MODE_TAG     = 3'd1,
		MODE_PI      = 3'd2,
		MODE_DECL    = 3'd3,
		MODE_COMMENT = 3'd4
	} mode_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LT     = "<";
	localparam logic [7:0] CH_GT     = ">";
	localparam logic [7:0] CH_BANG   = "!";
	localparam logic [7:0] CH_QMARK  = "?";
	localparam logic [7:0] CH_DASH   = "-";
	localparam logic [7:0] CH_LPAREN = "(";
	localparam logic [7:0] CH_RPAREN = ")";
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_UPPER_E = "E";
	localparam logic [7:0] CH_LOWER_E = "e";
	localparam logic [7:0] CH_LOWER_L = "l";
	localparam logic [7:0] CH_LOWER_M = "m";
	localparam logic [7:0] CH_LOWER_X = "x";
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_UPPER_A = "A";
	localparam logic [7:0] CH_UPPER_Z = "Z";

	// doctype spelled backward from the byte just before, entry 0 is 'p'
	localparam logic [5:0][7:0] DOCTYPE_BACK = "doctyp";

	typedef logic signed [BRACKET_BITS-1:0] bracket_t;
	localparam bracket_t BR_MAX = {1'b0, {(BRACKET_BITS-1){1'b1}}};
	localparam bracket_t BR_MIN = {1'b1, {(BRACKET_BITS-1){1'b0}}};

	typedef struct packed {
		mode_t                 mode;
		logic [DEPTH_BITS-1:0] nest_depth;
		logic [7:0]            quote_char;
		logic [7:0]            last_mark;
		bracket_t              bracket_balance;
		logic [5:0][7:0]       hist;
		logic [2:0]            bytes_seen;
	} state_t;

	typedef struct packed {
		state_t st;
		logic   keep;
	} step_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       part_end;
		logic [2:0] final_mode;
	} result_t;

	typedef struct packed {
		logic [1:0] cnt;
		result_t    first;
		result_t    second;
	} push_t;

	function automatic logic is_space(logic [7:0] n);
		return (n == CH_SPACE) || (n >= CH_TAB && n <= CH_CR);
	endfunction

	function automatic logic [7:0] to_lower(logic [7:0] c);
		return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + 8'd32 : c;
	endfunction

	function automatic mode_t start_of(logic [2:0] sm);
		return (sm > 3'd4) ? MODE_TEXT : mode_t'(sm);
	endfunction

	function automatic state_t clear_state(logic [2:0] sm);
		state_t s;
		s = '0;
		s.mode = start_of(sm);
		return s;
	endfunction

	// doctype and xml switches, else an ordinary character
	function automatic step_t letter_tail(state_t s, logic try_doctype);
		step_t r;
		logic  dt_match;
		r.st = s;
		r.keep = 1'b0;
		dt_match = 1'b1;
		for (int k = 0; k < 6; k++) begin
			if (to_lower(s.hist[k]) != DOCTYPE_BACK[k])
				dt_match = 1'b0;
		end
		if (try_doctype && s.mode == MODE_DECL && s.bytes_seen == 3'd7 && dt_match) begin
			r.st.mode = MODE_TAG;
		end else if (s.mode == MODE_PI && s.bytes_seen >= 3'd3 &&
			s.hist[0] == CH_LOWER_M && s.hist[1] == CH_LOWER_X) begin
			r.st.mode = MODE_TAG;
		end else begin
			r.keep = (s.mode == MODE_TEXT);
		end
		return r;
	endfunction

	// decide one byte against the state, return next state and keep flag
	function automatic step_t handle_byte(state_t s, logic [7:0] c, logic next_space);
		step_t      r;
		logic       have1;
		logic [7:0] p1;
		logic [7:0] p2;
		r.st = s;
		r.keep = 1'b0;
		have1 = (s.bytes_seen != 3'd0);
		p1 = s.hist[0];
		p2 = s.hist[1];
		unique case (c)
			CH_NUL: begin
			end
			CH_LT: begin
				if (next_space) begin
					r.keep = (s.mode == MODE_TEXT);
				end else if (s.mode == MODE_TEXT) begin
					r.st.last_mark = CH_LT;
					r.st.mode = MODE_TAG;
				end else if (s.mode == MODE_TAG && s.nest_depth != {DEPTH_BITS{1'b1}}) begin
					r.st.nest_depth = s.nest_depth + DEPTH_BITS'(1);
				end
			end
			CH_LPAREN, CH_RPAREN: begin
				if (s.mode == MODE_PI) begin
					if (s.last_mark != CH_DQUOTE && s.last_mark != CH_SQUOTE) begin
						r.st.last_mark = c;
						if (c == CH_LPAREN && s.bracket_balance != BR_MAX)
							r.st.bracket_balance = s.bracket_balance + bracket_t'(1);
						else if (c == CH_RPAREN && s.bracket_balance != BR_MIN)
							r.st.bracket_balance = s.bracket_balance - bracket_t'(1);
					end
				end else begin
					r.keep = (s.mode == MODE_TEXT);
				end
			end
			CH_GT: begin
				if (s.nest_depth != '0) begin
					r.st.nest_depth = s.nest_depth - DEPTH_BITS'(1);
				end else if (s.quote_char == CH_NUL) begin
					unique case (s.mode)
						MODE_TAG: begin
							r.st.last_mark = CH_GT;
							r.st.mode = MODE_TEXT;
						end
						MODE_PI: begin
							if (s.bracket_balance == '0 && s.last_mark != CH_DQUOTE &&
								have1 && p1 == CH_QMARK)
								r.st.mode = MODE_TEXT;
						end
						MODE_DECL: r.st.mode = MODE_TEXT;
						MODE_COMMENT: begin
							if (s.bytes_seen >= 3'd2 && p1 == CH_DASH && p2 == CH_DASH)
								r.st.mode = MODE_TEXT;
						end
						default: r.keep = 1'b1;
					endcase
				end
			end
			CH_DQUOTE, CH_SQUOTE: begin
				if (s.mode == MODE_PI && (!have1 || p1 != CH_BSLASH)) begin
					if (s.last_mark == c)
						r.st.last_mark = CH_NUL;
					else if (s.last_mark != CH_BSLASH)
						r.st.last_mark = c;
				end else if (s.mode == MODE_TEXT) begin
					r.keep = 1'b1;
				end
				if (s.mode != MODE_TEXT && have1 && p1 != CH_BSLASH &&
					(s.quote_char == CH_NUL || c == s.quote_char))
					r.st.quote_char = (s.quote_char != CH_NUL) ? CH_NUL : c;
			end
			CH_BANG: begin
				if (s.mode == MODE_TAG && have1 && p1 == CH_LT) begin
					r.st.mode = MODE_DECL;
					r.st.last_mark = CH_BANG;
				end else begin
					r.keep = (s.mode == MODE_TEXT);
				end
			end
			CH_DASH: begin
				if (s.mode == MODE_DECL && s.bytes_seen >= 3'd2 && p1 == CH_DASH && p2 == CH_BANG)
					r.st.mode = MODE_COMMENT;
				else
					r.keep = (s.mode == MODE_TEXT);
			end
			CH_QMARK: begin
				if (s.mode == MODE_TAG && have1 && p1 == CH_LT) begin
					r.st.bracket_balance = '0;
					r.st.mode = MODE_PI;
				end else begin
					r = letter_tail(s, 1'b1);
				end
			end
			CH_UPPER_E, CH_LOWER_E: r = letter_tail(s, 1'b1);
			CH_LOWER_L:             r = letter_tail(s, 1'b0);
			default:                r.keep = (s.mode == MODE_TEXT);
		endcase
		r.st.hist = {s.hist[4:0], c};
		if (s.bytes_seen != 3'd7)
			r.st.bytes_seen = s.bytes_seen + 3'd1;
		return r;
	endfunction

endpackage

### sv/htsu_outq.sv
// result queue that takes up to two results a cycle and hands out one while out_stall is low
`include "html_tag_stripper_unit_defines.svh"

module htsu_outq import htsu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    room,
	output result_t head,
	output logic    out_valid,
	input  logic    out_stall
);

	result_t                entries [QDEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCNT_BITS-1:0]   count_q;
	logic                   pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	assign head      = entries[rd_ptr_q];
	// room for a full pair of results, ignoring a pop in the same cycle
	assign room      = (count_q <= QCNT_BITS'(QDEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0)
			entries[wr_ptr_q] <= push.first;
		if (push.cnt == 2'd2)
			entries[wr_ptr_q + QPTR_BITS'(1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_BITS'(push.cnt);
			rd_ptr_q <= rd_ptr_q + QPTR_BITS'(pop);
			count_q  <= count_q + QCNT_BITS'(push.cnt) - QCNT_BITS'(pop);
		end
	end

	`HTSU_ASSERT_IMPLY(a_push_room, push.cnt != 2'd0, room, "push without room")
	`HTSU_ASSERT_ALWAYS(a_count_max, count_q <= QCNT_BITS'(QDEPTH), "queue overflow")
	`HTSU_ASSERT_NEXT(a_count_track, 1'b1,
		count_q == $past(count_q) + QCNT_BITS'($past(push.cnt)) - QCNT_BITS'($past(pop)),
		"queue count mismatch")

endmodule

### sv/html_tag_stripper_unit.sv
// html tag stripper top level: input register, byte decision logic, result queue
// order: a byte enters the input register, is held until its successor arrives and
//   is decided with it, then passes through the result queue
// throughput: one byte per cycle unless stalled; a part end with two kept bytes
//   yields two results; the four-entry queue at one result per cycle sets the pace
// reset: asynchronous active low, clears start_mode, all part state and the queue
`include "html_tag_stripper_unit_defines.svh"

module html_tag_stripper_unit import htsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       part_last,
	// result channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       part_end,
	output logic [2:0] final_mode,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] start_mode
);

	// input register
	logic       valid_s1;
	logic [7:0] data_byte_s1;
	logic       part_last_s1;

	// part state
	state_t     state_q;
	logic [7:0] held_byte_q;
	logic       held_valid_q;
	logic [2:0] start_mode_q;

	logic       room;
	logic       proc;
	logic       in_take;
	step_t      r1;
	step_t      r2;
	state_t     st1;
	logic       k1;
	push_t      push;
	result_t    head;

	assign cfg_ready = 1'b1;

	// the item in the input register is decided once the queue can take two results
	assign proc     = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			data_byte_s1 <= data_byte;
			part_last_s1 <= part_last;
		end
	end

	// decision logic: held byte first, with the new byte as its successor,
	// then the new byte itself when it closes the part
	always_comb begin
		r1   = handle_byte(state_q, held_byte_q, is_space(data_byte_s1));
		st1  = held_valid_q ? r1.st : state_q;
		k1   = held_valid_q && r1.keep;
		r2   = handle_byte(st1, data_byte_s1, 1'b0);
		push = '0;
		if (proc) begin
			if (!part_last_s1) begin
				push.cnt = k1 ? 2'd1 : 2'd0;
				push.first = '{out_byte: held_byte_q, byte_valid: 1'b1,
					part_end: 1'b0, final_mode: 3'd0};
			end else if (k1 && r2.keep) begin
				push.cnt = 2'd2;
				push.first = '{out_byte: held_byte_q, byte_valid: 1'b1,
					part_end: 1'b0, final_mode: 3'd0};
				push.second = '{out_byte: data_byte_s1, byte_valid: 1'b1,
					part_end: 1'b1, final_mode: r2.st.mode};
			end else begin
				// one closing result: the single kept byte, or an empty marker
				push.cnt = 2'd1;
				push.first.out_byte   = k1 ? held_byte_q : (r2.keep ? data_byte_s1 : 8'd0);
				push.first.byte_valid = k1 || r2.keep;
				push.first.part_end   = 1'b1;
				push.first.final_mode = r2.st.mode;
			end
		end
	end

	// state update; config write sets start_mode_q, and the mode only while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= clear_state(3'd0);
			held_byte_q  <= 8'd0;
			held_valid_q <= 1'b0;
			start_mode_q <= 3'd0;
		end else begin
			if (proc) begin
				if (part_last_s1) begin
					state_q      <= clear_state(start_mode_q);
					held_byte_q  <= 8'd0;
					held_valid_q <= 1'b0;
				end else begin
					state_q      <= st1;
					held_byte_q  <= data_byte_s1;
					held_valid_q <= 1'b1;
				end
			end else if (cfg_valid && cfg_ready && !held_valid_q &&
				state_q.bytes_seen == 3'd0) begin
				// no part open: new start mode applies at once
				state_q.mode <= start_of(start_mode);
			end
			if (cfg_valid && cfg_ready)
				start_mode_q <= start_mode;
		end
	end

	htsu_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.head      (head),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	assign out_byte   = head.out_byte;
	assign byte_valid = head.byte_valid;
	assign part_end   = head.part_end;
	assign final_mode = head.final_mode;

	`HTSU_ASSERT_NEXT(a_part_close, proc && part_last_s1,
		!held_valid_q && state_q.bytes_seen == 3'd0, "part state not cleared")
	`HTSU_ASSERT_NEXT(a_hold_byte, proc && !part_last_s1,
		held_valid_q && held_byte_q == $past(data_byte_s1), "byte not held")
	`HTSU_ASSERT_IMPLY(a_close_result, proc && part_last_s1,
		push.cnt != 2'd0, "part closed without a result")

endmodule
